/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the lidar point decimator.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Invariant checked at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("invariant violated");
// Same-cycle implication checked outside reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication violated");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* hw/rtl/lpd_pkg.sv */
// Shared types, constants and tables of the lidar point decimator.
// No dependencies; imported by every module of the block.
package lpd_pkg;

    localparam int MAX_BEAMS    = 1024;
    localparam int CORDIC_ITERS = 16;
    localparam int CNT_W        = $clog2(MAX_BEAMS) + 1;
    localparam int ACC_W        = 19;
    localparam int ITER_W       = 5;

    localparam logic [ACC_W-1:0] FULL_TURN_MDEG = ACC_W'(360000);
    localparam logic [ACC_W-1:0] QUARTER_MDEG   = ACC_W'(90000);
    localparam logic [30:0]      INV_GAIN_Q30   = 31'd652032874;

    // millidegrees to Q2.30 radians: round(pi*2^30) = 180000*Z_QUOT + Z_REM,
    // so z = r*Z_QUOT + floor((r*Z_REM + Z_ROUND) / 180000)
    localparam logic [14:0]      Z_QUOT         = 15'd18740;
    localparam logic [15:0]      Z_REM          = 16'd59426;
    localparam logic [16:0]      Z_ROUND        = 17'd90000;
    // 180000 = 32 * 5625; divide by 5625 as a multiply by ceil(2^41 / 5625)
    localparam logic [28:0]      Z_RECIP        = 29'd390937468;
    localparam int               Z_RECIP_SHIFT  = 41;

    typedef enum logic [1:0] {
        CFG_ANGLE_STEP      = 2'd0,
        CFG_SIMPLIFY_THRESH = 2'd1,
        CFG_Y_MAX           = 2'd2
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MULZ,
        ST_RECIP,
        ST_CINIT,
        ST_CORD,
        ST_FOLD,
        ST_MULX,
        ST_MULY,
        ST_RNDY,
        ST_SQX,
        ST_SQY,
        ST_DECIDE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic mul_z;
        logic recip;
        logic cord_init;
        logic cord_step;
        logic fold;
        logic mul_x;
        logic mul_y;
        logic rnd_y;
        logic sq_x;
        logic sq_y;
        logic decide;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic over_max;
        logic cord_done;
        logic pass;
        logic out_free;
    } status_t;

    // arctan(2^-i) in Q2.30
    function automatic logic [31:0] atan_q30(input logic [ITER_W-1:0] i);
        case (i)
            5'd0:    return 32'd843314856;
            5'd1:    return 32'd497837829;
            5'd2:    return 32'd263043836;
            5'd3:    return 32'd133525158;
            5'd4:    return 32'd67021686;
            5'd5:    return 32'd33543515;
            5'd6:    return 32'd16775850;
            5'd7:    return 32'd8388437;
            5'd8:    return 32'd4194282;
            5'd9:    return 32'd2097149;
            5'd10:   return 32'd1048575;
            5'd11:   return 32'd524287;
            5'd12:   return 32'd262143;
            5'd13:   return 32'd131071;
            5'd14:   return 32'd65535;
            5'd15:   return 32'd32767;
            5'd16:   return 32'd16383;
            5'd17:   return 32'd8191;
            5'd18:   return 32'd4095;
            5'd19:   return 32'd2047;
            5'd20:   return 32'd1023;
            5'd21:   return 32'd511;
            5'd22:   return 32'd255;
            5'd23:   return 32'd127;
            default: return 32'd0;
        endcase
    endfunction

endpackage

/* hw/rtl/lidar_polar_point_decimator_core.sv */
// Top level of the lidar point decimator: sequencer plus datapath.
// Depends on lpd_pkg, lpd_ctrl and lpd_datapath.
//
// One range sample enters per transfer on the slave stream; the beam angle is
// the beam index times angle_step_mdeg, wrapped at 360 degrees. Each sample
// becomes x = -cos*range, y = sin*range (Q1.15 CORDIC, results rounded to mm).
// The first point of a scan is always kept; later points are kept only when
// their squared distance from the last kept point exceeds the threshold
// squared, and a kept point is sent only if 0 < y < y_max_mm. The sample
// flagged by tlast is not converted: it closes the scan with a marker
// transfer (tlast high, tuser low, x = y = 0, beam_index of that sample).
// Samples beyond MAX_BEAMS in one scan are swallowed without a result.
// Steps of a converted sample, in order: scale millidegrees to radians by a
// split constant multiply and a reciprocal multiply, load the CORDIC, run
// CORDIC_ITERS = 16 CORDIC steps, one quadrant fold, the x and y products on
// the shared 18x18 multiplier with a rounding step for y, the squared x and y
// distances on the same multiplier and one decision; a scan-end sample skips
// them all. The input is ready again only once the sequencer is back in idle,
// so no new sample is taken before the last one is through. A result waiting
// in the output register does not hold up the next sample unless a second
// result is due before the first is taken. Configuration writes take effect
// at once and are meant for idle periods.
module lidar_polar_point_decimator_core (
    input  logic        clk,
    input  logic        rst_n,
    // slave stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] range_mm
    input  logic        s_axis_tlast,   // scan_last
    // master stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [16:0] x_mm, [33:17] y_mm, [43:34] beam_index
    output logic        m_axis_tuser,   // point_valid
    output logic        m_axis_tlast,   // scan_end
    // configuration writes
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import lpd_pkg::*;

    cmd_t    cmd;
    status_t st;

    lpd_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tlast  (s_axis_tlast),
        .st            (st),
        .s_axis_tready (s_axis_tready),
        .cmd           (cmd)
    );

    lpd_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .st            (st),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

/* hw/rtl/lpd_ctrl.sv */
// Sequencer of the lidar point decimator: walks one sample through the datapath.
// Depends on lpd_pkg.
module lpd_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    input  logic             s_axis_tlast,
    input  lpd_pkg::status_t st,
    output logic             s_axis_tready,
    output lpd_pkg::cmd_t    cmd
);
    import lpd_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        s_axis_tready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd.load = 1'b1;
                    if (s_axis_tlast)
                        state_next = ST_EMIT;
                    else if (!st.over_max)
                        state_next = ST_MULZ;
                end
            end
            ST_MULZ:
            begin
                cmd.mul_z  = 1'b1;
                state_next = ST_RECIP;
            end
            ST_RECIP:
            begin
                cmd.recip  = 1'b1;
                state_next = ST_CINIT;
            end
            ST_CINIT:
            begin
                cmd.cord_init = 1'b1;
                state_next    = ST_CORD;
            end
            ST_CORD:
            begin
                cmd.cord_step = 1'b1;
                if (st.cord_done)
                    state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                cmd.fold   = 1'b1;
                state_next = ST_MULX;
            end
            ST_MULX:
            begin
                cmd.mul_x  = 1'b1;
                state_next = ST_MULY;
            end
            ST_MULY:
            begin
                cmd.mul_y  = 1'b1;
                state_next = ST_RNDY;
            end
            ST_RNDY:
            begin
                cmd.rnd_y  = 1'b1;
                state_next = ST_SQX;
            end
            ST_SQX:
            begin
                cmd.sq_x   = 1'b1;
                state_next = ST_SQY;
            end
            ST_SQY:
            begin
                cmd.sq_y   = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = st.pass ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/lpd_datapath.sv */
// Datapath of the lidar point decimator: angle bookkeeping, radian scaling,
// CORDIC, shared multiplier, decimation test and output register. Uses lpd_pkg.
`include "assert_macros.svh"
module lpd_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  lpd_pkg::cmd_t    cmd,
    output lpd_pkg::status_t st,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [15:0]      cfg_data,
    input  logic [15:0]      s_axis_tdata,
    input  logic             s_axis_tlast,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [47:0]      m_axis_tdata,
    output logic             m_axis_tuser,
    output logic             m_axis_tlast
);
    import lpd_pkg::*;

    function automatic logic signed [15:0] to_q15(input logic signed [33:0] v);
        logic signed [33:0] t;
        t = (v + 34'sd16384) >>> 15;
        if (t > 34'sd32767)
            return 16'sh7fff;
        if (t < -34'sd32768)
            return 16'sh8000;
        return t[15:0];
    endfunction

    // round half away from zero, divide by 2^15
    function automatic logic signed [17:0] rnd_mm(input logic signed [35:0] p);
        logic [35:0] mag;
        logic [35:0] q;
        mag = p[35] ? 36'(-p) : 36'(p);
        q   = (mag + 36'd16384) >> 15;
        return p[35] ? -$signed(q[17:0]) : $signed(q[17:0]);
    endfunction

    // configuration
    logic [11:0]          step_reg, step_next;
    logic [19:0]          thr_sq_reg, thr_sq_next;
    logic [15:0]          ymax_reg, ymax_next;
    // scan state
    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 first_reg, first_next;
    logic signed [16:0]   lastx_reg, lastx_next;
    logic signed [16:0]   lasty_reg, lasty_next;
    logic                 outv_reg, outv_next;
    // per-sample payload
    logic [15:0]          range_reg, range_next;
    logic [9:0]           idx_reg, idx_next;
    logic [1:0]           quad_reg, quad_next;
    logic [16:0]          rsd_reg, rsd_next;
    logic                 se_reg, se_next;
    logic [30:0]          zq_reg, zq_next;
    logic [32:0]          zm_reg, zm_next;
    logic [56:0]          zp_reg, zp_next;
    logic signed [33:0]   cx_reg, cx_next;
    logic signed [33:0]   cy_reg, cy_next;
    logic signed [33:0]   cz_reg, cz_next;
    logic [ITER_W-1:0]    ci_reg, ci_next;
    logic signed [16:0]   tc_reg, tc_next;
    logic signed [16:0]   ts_reg, ts_next;
    logic signed [35:0]   prod_reg, prod_next;
    logic signed [16:0]   x_reg, x_next;
    logic signed [16:0]   y_reg, y_next;
    logic [35:0]          sq1_reg, sq1_next;
    logic [35:0]          sq2_reg, sq2_next;
    logic [47:0]          odata_reg, odata_next;
    logic                 opv_reg, opv_next;
    logic                 ose_reg, ose_next;

    logic [ACC_W-1:0]     rsd_full;
    logic [1:0]           quad_c;
    logic [ACC_W-1:0]     acc_sum;
    logic [30:0]          zsum;
    logic signed [33:0]   shx, shy, atv;
    logic signed [15:0]   cr, sr;
    logic signed [16:0]   cr17, sr17;
    logic signed [17:0]   ma, mb;
    logic signed [35:0]   mp;
    logic signed [17:0]   dx, dy;
    logic [36:0]          d2;
    logic                 keep;
    logic                 y_ok;
    logic                 over_max;

    // quadrant split of the current angle
    always_comb
    begin
        if (acc_reg >= ACC_W'(3 * 90000))
        begin
            quad_c   = 2'd3;
            rsd_full = acc_reg - ACC_W'(3 * 90000);
        end
        else if (acc_reg >= ACC_W'(2 * 90000))
        begin
            quad_c   = 2'd2;
            rsd_full = acc_reg - ACC_W'(2 * 90000);
        end
        else if (acc_reg >= QUARTER_MDEG)
        begin
            quad_c   = 2'd1;
            rsd_full = acc_reg - QUARTER_MDEG;
        end
        else
        begin
            quad_c   = 2'd0;
            rsd_full = acc_reg;
        end
    end

    assign over_max = (cnt_reg >= CNT_W'(MAX_BEAMS));
    assign acc_sum  = acc_reg + ACC_W'(step_reg);
    // whole part plus the scaled fraction; always below 2^31
    assign zsum     = zq_reg + 31'(zp_reg[Z_RECIP_SHIFT +: 16]);
    assign shx      = cx_reg >>> ci_reg;
    assign shy      = cy_reg >>> ci_reg;
    assign atv      = $signed({2'b00, atan_q30(ci_reg)});
    assign cr       = to_q15(cx_reg);
    assign sr       = to_q15(cy_reg);
    assign cr17     = {cr[15], cr};
    assign sr17     = {sr[15], sr};
    assign dx       = $signed({x_reg[16], x_reg}) - $signed({lastx_reg[16], lastx_reg});
    assign dy       = $signed({y_reg[16], y_reg}) - $signed({lasty_reg[16], lasty_reg});
    assign d2       = 37'(sq1_reg) + 37'(sq2_reg);
    assign keep     = first_reg || (d2 > 37'(thr_sq_reg));
    assign y_ok     = (y_reg > 17'sd0) && ($signed({2'b00, ymax_reg}) > $signed({y_reg[16], y_reg}));

    // shared multiplier
    always_comb
    begin
        if (cmd.sq_x)
        begin
            ma = dx;
            mb = dx;
        end
        else if (cmd.sq_y)
        begin
            ma = dy;
            mb = dy;
        end
        else if (cmd.mul_y)
        begin
            ma = {ts_reg[16], ts_reg};
            mb = $signed({2'b00, range_reg});
        end
        else
        begin
            ma = {tc_reg[16], tc_reg};
            mb = $signed({2'b00, range_reg});
        end
    end
    assign mp = ma * mb;

    always_comb
    begin
        step_next  = step_reg;
        thr_sq_next = thr_sq_reg;
        ymax_next  = ymax_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        first_next = first_reg;
        lastx_next = lastx_reg;
        lasty_next = lasty_reg;
        range_next = range_reg;
        idx_next   = idx_reg;
        quad_next  = quad_reg;
        rsd_next   = rsd_reg;
        se_next    = se_reg;
        zq_next    = zq_reg;
        zm_next    = zm_reg;
        zp_next    = zp_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        cz_next    = cz_reg;
        ci_next    = ci_reg;
        tc_next    = tc_reg;
        ts_next    = ts_reg;
        prod_next  = prod_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        sq1_next   = sq1_reg;
        sq2_next   = sq2_reg;
        odata_next = odata_reg;
        opv_next   = opv_reg;
        ose_next   = ose_reg;
        outv_next  = outv_reg && !m_axis_tready;

        if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_ANGLE_STEP:      step_next   = cfg_data[11:0];
                CFG_SIMPLIFY_THRESH: thr_sq_next = 20'(cfg_data[9:0]) * 20'(cfg_data[9:0]);
                CFG_Y_MAX:           ymax_next   = cfg_data;
                default:             ;
            endcase
        end

        if (cmd.load)
        begin
            if (s_axis_tlast)
            begin
                // scan end: marker carries the dropped sample's index
                x_next     = '0;
                y_next     = '0;
                idx_next   = 10'(cnt_reg);
                se_next    = 1'b1;
                acc_next   = '0;
                cnt_next   = '0;
                first_next = 1'b1;
            end
            else if (!over_max)
            begin
                range_next = s_axis_tdata;
                idx_next   = 10'(cnt_reg);
                quad_next  = quad_c;
                rsd_next   = rsd_full[16:0];
                se_next    = 1'b0;
                cnt_next   = cnt_reg + CNT_W'(1);
                acc_next   = (acc_sum >= FULL_TURN_MDEG) ? acc_sum - FULL_TURN_MDEG : acc_sum;
            end
        end

        if (cmd.mul_z)
        begin
            zq_next = 31'(rsd_reg) * 31'(Z_QUOT);
            zm_next = 33'(rsd_reg) * 33'(Z_REM) + 33'(Z_ROUND);
        end

        // drop the factor 32 by the shift, then 1/5625 by reciprocal multiply
        if (cmd.recip)
            zp_next = 57'(zm_reg[32:5]) * 57'(Z_RECIP);

        if (cmd.cord_init)
        begin
            cx_next = $signed({3'b000, INV_GAIN_Q30});
            cy_next = '0;
            cz_next = $signed({3'b000, zsum});
            ci_next = '0;
        end

        if (cmd.cord_step)
        begin
            if (!cz_reg[33])
            begin
                cx_next = cx_reg - shy;
                cy_next = cy_reg + shx;
                cz_next = cz_reg - atv;
            end
            else
            begin
                cx_next = cx_reg + shy;
                cy_next = cy_reg - shx;
                cz_next = cz_reg + atv;
            end
            ci_next = ci_reg + ITER_W'(1);
        end

        if (cmd.fold)
        begin
            case (quad_reg)
                2'd0:
                begin
                    tc_next = cr17;
                    ts_next = sr17;
                end
                2'd1:
                begin
                    tc_next = -sr17;
                    ts_next = cr17;
                end
                2'd2:
                begin
                    tc_next = -cr17;
                    ts_next = -sr17;
                end
                default:
                begin
                    tc_next = sr17;
                    ts_next = -cr17;
                end
            endcase
        end

        if (cmd.mul_x)
            prod_next = mp;

        if (cmd.mul_y)
        begin
            x_next    = 17'(-rnd_mm(prod_reg));
            prod_next = mp;
        end

        if (cmd.rnd_y)
            y_next = 17'(rnd_mm(prod_reg));

        if (cmd.sq_x)
            sq1_next = 36'(mp);

        if (cmd.sq_y)
            sq2_next = 36'(mp);

        if (cmd.decide && keep)
        begin
            first_next = 1'b0;
            lastx_next = x_reg;
            lasty_next = y_reg;
        end

        if (cmd.emit)
        begin
            odata_next = {4'b0000, idx_reg, y_reg, x_reg};
            opv_next   = !se_reg;
            ose_next   = se_reg;
            outv_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= 12'd360;
            thr_sq_reg <= 20'd400;
            ymax_reg   <= 16'd30000;
            acc_reg    <= '0;
            cnt_reg    <= '0;
            first_reg  <= 1'b1;
            lastx_reg  <= '0;
            lasty_reg  <= '0;
            outv_reg   <= 1'b0;
            ci_reg     <= '0;
        end
        else
        begin
            step_reg   <= step_next;
            thr_sq_reg <= thr_sq_next;
            ymax_reg   <= ymax_next;
            acc_reg    <= acc_next;
            cnt_reg    <= cnt_next;
            first_reg  <= first_next;
            lastx_reg  <= lastx_next;
            lasty_reg  <= lasty_next;
            outv_reg   <= outv_next;
            ci_reg     <= ci_next;
        end
    end

    always_ff @(posedge clk)
    begin
        range_reg <= range_next;
        idx_reg   <= idx_next;
        quad_reg  <= quad_next;
        rsd_reg   <= rsd_next;
        se_reg    <= se_next;
        zq_reg    <= zq_next;
        zm_reg    <= zm_next;
        zp_reg    <= zp_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        cz_reg    <= cz_next;
        tc_reg    <= tc_next;
        ts_reg    <= ts_next;
        prod_reg  <= prod_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        sq1_reg   <= sq1_next;
        sq2_reg   <= sq2_next;
        odata_reg <= odata_next;
        opv_reg   <= opv_next;
        ose_reg   <= ose_next;
    end

    assign st.over_max  = over_max;
    assign st.cord_done = (ci_reg == ITER_W'(CORDIC_ITERS - 1));
    assign st.pass      = keep && y_ok;
    assign st.out_free  = !outv_reg || m_axis_tready;

    assign m_axis_tvalid = outv_reg;
    assign m_axis_tdata  = odata_reg;
    assign m_axis_tuser  = opv_reg;
    assign m_axis_tlast  = ose_reg;

    `ASSERT_IMPLIES(a_no_overwrite, clk, rst_n, cmd.emit && outv_reg, m_axis_tready)
    `ASSERT_ALWAYS(a_angle_range, clk, rst_n, acc_reg < FULL_TURN_MDEG)
    `ASSERT_ALWAYS(a_beam_bound, clk, rst_n, cnt_reg <= CNT_W'(MAX_BEAMS))
    `ASSERT_IMPLIES(a_decide_order, clk, rst_n, cmd.decide, $past(cmd.sq_y))

endmodule

/* tb/lpd_checker.sv */
// Checker for the lidar point decimator: watches both streams and the register port,
// predicts every result and compares it field by field.
// Depends on lpd_pkg.
module lpd_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [47:0] m_axis_tdata,
    input  logic        m_axis_tuser,
    input  logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          errors,
    output int          pending
);
    import lpd_pkg::*;

    typedef struct {
        logic signed [16:0] x_mm;
        logic signed [16:0] y_mm;
        logic [9:0]         beam_index;
        logic               point_valid;
        logic               scan_end;
    } point_t;

    localparam longint ATAN_Q30 [24] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287,
        262143, 131071, 65535, 32767, 16383, 8191,
        4095, 2047, 1023, 511, 255, 127
    };

    point_t expected_points[$];

    logic [11:0] step_mdeg;
    logic [9:0]  thresh_mm;
    logic [15:0] y_max;
    int unsigned angle_mdeg;
    int unsigned beam_cnt;
    longint      kept_x;
    longint      kept_y;
    bit          first_point;

    assign pending = expected_points.size();

    function automatic longint round_q15(input longint v);
        longint q;
        q = (v + 16384) >>> 15;
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        return q;
    endfunction

    function automatic longint times_range(input longint trig, input longint rng);
        longint p;
        longint q;
        p = trig * rng;
        q = ((p < 0 ? -p : p) + 16384) >>> 15;
        return p < 0 ? -q : q;
    endfunction

    function automatic void polar_trig(input int unsigned mdeg, output longint c,
                                       output longint s);
        int unsigned quad;
        longint      z;
        longint      cx;
        longint      cy;
        longint      dx;
        longint      dy;
        longint      cr;
        longint      sr;
        quad = mdeg / 90000;
        z  = longint'((64'(mdeg - quad * 90000) * 64'd3373259426 + 64'd90000) / 64'd180000);
        cx = 652032874;
        cy = 0;
        for (int i = 0; i < CORDIC_ITERS && i < 24; i++)
        begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (z >= 0)
            begin
                cx -= dx; cy += dy; z -= ATAN_Q30[i];
            end
            else
            begin
                cx += dx; cy -= dy; z += ATAN_Q30[i];
            end
        end
        cr = round_q15(cx);
        sr = round_q15(cy);
        case (quad)
            0:       begin c = cr;  s = sr;  end
            1:       begin c = -sr; s = cr;  end
            2:       begin c = -cr; s = -sr; end
            default: begin c = sr;  s = -cr; end
        endcase
    endfunction

    // one accepted sample -> zero or one expected result
    task automatic predict_point(input logic [15:0] range_mm, input logic last);
        longint c;
        longint s;
        longint px;
        longint py;
        longint ddx;
        longint ddy;
        int unsigned idx;
        point_t p;
        if (last)
        begin
            p = '{0, 0, beam_cnt[9:0], 1'b0, 1'b1};
            expected_points.insert(expected_points.size(), p);
            angle_mdeg  = 0;
            beam_cnt    = 0;
            first_point = 1;
            return;
        end
        if (beam_cnt >= MAX_BEAMS)
            return;
        polar_trig(angle_mdeg, c, s);
        px  = -times_range(c, range_mm);
        py  = times_range(s, range_mm);
        idx = beam_cnt;
        beam_cnt++;
        angle_mdeg += step_mdeg;
        if (angle_mdeg >= 360000)
            angle_mdeg -= 360000;
        if (!first_point)
        begin
            ddx = px - kept_x;
            ddy = py - kept_y;
            if (ddx * ddx + ddy * ddy <= longint'(thresh_mm) * thresh_mm)
                return;
        end
        first_point = 0;
        kept_x = px;
        kept_y = py;
        if (py > 0 && py < y_max)
        begin
            p = '{17'(px), 17'(py), idx[9:0], 1'b1, 1'b0};
            expected_points.insert(expected_points.size(), p);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_mdeg   = 12'd360;
            thresh_mm   = 10'd20;
            y_max       = 16'd30000;
            angle_mdeg  = 0;
            beam_cnt    = 0;
            kept_x      = 0;
            kept_y      = 0;
            first_point = 1;
            errors      = 0;
            expected_points.delete();
        end
        else
        begin
            // result side first: an input transfer of this edge cannot land yet
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_points.size() == 0)
                begin
                    $error("result transfer with nothing expected: %h", m_axis_tdata);
                    errors++;
                end
                else
                begin
                    point_t e;
                    e = expected_points.pop_front();
                    if (m_axis_tdata[16:0] !== e.x_mm)
                    begin
                        $error("x_mm expected %0d got %0d", e.x_mm,
                               $signed(m_axis_tdata[16:0]));
                        errors++;
                    end
                    if (m_axis_tdata[33:17] !== e.y_mm)
                    begin
                        $error("y_mm expected %0d got %0d", e.y_mm,
                               $signed(m_axis_tdata[33:17]));
                        errors++;
                    end
                    if (m_axis_tdata[43:34] !== e.beam_index)
                    begin
                        $error("beam_index expected %0d got %0d", e.beam_index,
                               m_axis_tdata[43:34]);
                        errors++;
                    end
                    if (m_axis_tuser !== e.point_valid)
                    begin
                        $error("point_valid expected %0b got %0b", e.point_valid,
                               m_axis_tuser);
                        errors++;
                    end
                    if (m_axis_tlast !== e.scan_end)
                    begin
                        $error("scan_end expected %0b got %0b", e.scan_end, m_axis_tlast);
                        errors++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_point(s_axis_tdata, s_axis_tlast);
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    CFG_ANGLE_STEP:      step_mdeg = cfg_data[11:0];
                    CFG_SIMPLIFY_THRESH: thresh_mm = cfg_data[9:0];
                    CFG_Y_MAX:           y_max     = cfg_data;
                    default:             ;
                endcase
            end
        end
    end

endmodule

/* tb/testbench.sv */
// Top of the lidar point decimator testbench: clock, reset, stimulus and verdict.
// Depends on lpd_pkg, lpd_checker and the RTL top level.
module testbench;
    import lpd_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    int          errors;
    int          pending;

    int          burst_left;
    bit          hold_req;
    logic [15:0] last_range;

    lidar_polar_point_decimator_core u_top (.*);

    lpd_checker u_checker (.*);

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // receiver: one of four stall patterns, redrawn at random; one long hold-off on request
    initial
    begin
        int mode;
        int left;
        m_axis_tready = 1'b0;
        mode = 0;
        left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 0;
                m_axis_tready <= 1'b0;
                repeat (600) @(posedge clk);
            end
            if (left == 0)
            begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(10, 200);
            end
            left--;
            case (mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= $urandom_range(0, 1);
                2:       m_axis_tready <= ($urandom_range(0, 9) == 0);
                default: m_axis_tready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // one sample transfer; sender works in bursts with random gaps between them
    task automatic send_sample(input logic [15:0] range_mm, input logic last);
        if (burst_left == 0)
        begin
            int gap;
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 80);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= range_mm;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        burst_left--;
        last_range = range_mm;
    endtask

    // wait out every expected result plus the datapath latency of a silent sample
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic set_regs(input logic [15:0] step, input logic [15:0] thresh,
                            input logic [15:0] ymax);
        wait_idle();
        write_reg(CFG_ANGLE_STEP, step);
        write_reg(CFG_SIMPLIFY_THRESH, thresh);
        write_reg(CFG_Y_MAX, ymax);
        cfg_we <= 1'b0;
    endtask

    // full-range noise now and then, otherwise a surface that drifts slowly
    function automatic logic [15:0] next_range();
        case ($urandom_range(0, 9))
            0:       return 16'($urandom_range(0, 65535));
            1:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: return last_range + 16'($signed($urandom_range(0, 200)) - 100);
        endcase
    endfunction

    task automatic run_scan(input int len);
        for (int i = 0; i < len - 1; i++)
            send_sample(next_range(), 1'b0);
        send_sample(next_range(), 1'b1);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_ANGLE_STEP;
        cfg_data      = '0;
        hold_req      = 0;
        burst_left    = 0;
        last_range    = 16'd5000;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings, range extremes, one-sample scan
        send_sample(16'd0, 1'b1);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'd0, 1'b0);
        send_sample(16'd1, 1'b0);
        send_sample(16'd29000, 1'b0);
        send_sample(16'h8000, 1'b1);
        // no decimation, widest window, coarse step within the first quadrant
        set_regs(16'd3600, 16'd0, 16'hFFFF);
        for (int i = 0; i < 8; i++)
            send_sample(i[0] ? 16'hFFFF : 16'h7FFF, 1'b0);
        send_sample(16'd100, 1'b1);
        // first point kept but filtered by an empty window; zero step with large threshold drops the rest
        set_regs(16'd0, 16'd1000, 16'd0);
        send_sample(16'd2000, 1'b0);
        send_sample(16'd2000, 1'b0);
        send_sample(16'd2000, 1'b1);

        // short random scans under several settings, extremes among them
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0:       set_regs(16'd360, 16'd20, 16'd30000);
                1:       set_regs(16'd3600, 16'd0, 16'hFFFF);
                2:       set_regs(16'd1, 16'd1000, 16'hFFFF);
                3:       set_regs(16'd0, 16'd0, 16'd65535);
                4:       set_regs(16'hFFF, 16'h3FF, 16'd40000);
                default: set_regs(16'($urandom_range(1, 3600)), 16'($urandom_range(0, 1000)),
                                  16'($urandom_range(0, 65535)));
            endcase
            for (int n = 0; n < 8; )
            begin
                int len;
                len = $urandom_range(0, 7) == 0 ? $urandom_range(1, 3)
                                                : $urandom_range(4, 8);
                if (phase == 3 && n == 0)
                    hold_req = 1;
                run_scan(len);
                n += len;
            end
        end

        // too many beams: one scan past the beam limit, with a zero threshold and the widest window
        set_regs(16'd3600, 16'd0, 16'hFFFF);
        run_scan(MAX_BEAMS + 6);

        wait_idle();
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #200000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/lpd_pkg.sv
hw/rtl/lpd_ctrl.sv
hw/rtl/lpd_datapath.sv
hw/rtl/lidar_polar_point_decimator_core.sv
tb/lpd_checker.sv
tb/testbench.sv
